>>> design/hsl_to_rgb_fixed_point_assert.svh
// ----------------------------------------------------------------------------
// hsl_to_rgb_fixed_point assertion macros
// shared assertion forms for the converter checker
// ----------------------------------------------------------------------------
`ifndef HSL_TO_RGB_FIXED_POINT_ASSERT_SVH
`define HSL_TO_RGB_FIXED_POINT_ASSERT_SVH

// same-cycle implication, quiet during reset
`define HSL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hsl_to_rgb_fixed_point: assertion failed");

// next-cycle implication, quiet during reset
`define HSL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hsl_to_rgb_fixed_point: assertion failed");

// next-cycle implication that also holds across reset
`define HSL_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("hsl_to_rgb_fixed_point: assertion failed");

`endif

>>> design/hsl_pkg.sv
// ----------------------------------------------------------------------------
// hsl_pkg
// field widths, channel codes and pipeline control types for the converter
// ----------------------------------------------------------------------------
`default_nettype none

package hsl_pkg;

    // port field widths
    localparam int unsigned HUE_W   = 15;
    localparam int unsigned LUM_W   = 13;
    localparam int unsigned SAT_W   = 13;
    localparam int unsigned SCALE_W = 8;
    localparam int unsigned CHAN_W  = 8;

    // saturation level of a channel
    localparam int unsigned CHAN_MAX = 255;

    // lightness-plus-saturation sum and scaled channel level widths
    localparam int unsigned MIX_W = LUM_W + 1;
    localparam int unsigned LEV_W = LUM_W + SCALE_W + 1;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } t_chan;

    // which channel carries max, min and ramp
    typedef struct packed {
        t_chan top;
        t_chan lo;
        t_chan ramp;
    } t_route;

    // per-beat control that travels down the pipe
    typedef struct packed {
        logic   valid;
        t_route route;
        logic   low_half;
    } t_ctrl;

    // sector index to channel roles
    function automatic t_route route_of(input logic [2:0] m);
        t_route r;
        unique case (m)
            3'd0:    r = '{top: CH_RED,   lo: CH_GREEN, ramp: CH_BLUE};
            3'd1:    r = '{top: CH_RED,   lo: CH_BLUE,  ramp: CH_GREEN};
            3'd2:    r = '{top: CH_GREEN, lo: CH_BLUE,  ramp: CH_RED};
            3'd3:    r = '{top: CH_GREEN, lo: CH_RED,   ramp: CH_BLUE};
            3'd4:    r = '{top: CH_BLUE,  lo: CH_RED,   ramp: CH_GREEN};
            3'd5:    r = '{top: CH_BLUE,  lo: CH_GREEN, ramp: CH_RED};
            default: r = '{top: CH_RED,   lo: CH_GREEN, ramp: CH_BLUE};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/hsl_to_rgb_fixed_point.sv
// ----------------------------------------------------------------------------
// hsl_to_rgb_fixed_point
// pipelined HSL to 8-bit RGB colour converter in fixed point
// ----------------------------------------------------------------------------
// usage:
//   input channel: i_valid / o_stall with i_hue, i_lightness, i_saturation,
//   i_scale; a beat is taken on a rising edge with i_valid high and o_stall low.
//   output channel: o_valid / i_stall with o_red, o_green, o_blue; a beat is
//   taken on a rising edge with o_valid high and i_stall low.
//   path: an accepted beat moves through the stage registers in order, and
//   o_valid is driven by the last of them.
//   throughput: one beat per cycle, set by the six-stage pipeline in which
//   every stage takes a new beat on each cycle that the pipe advances.
//   stall: while a result waits with i_stall high the whole pipe holds and
//   o_stall goes high; empty slots keep moving otherwise, so bubbles are not
//   a cause for stalling the input.
//   reset: i_rst_n low on a rising edge clears every stage valid bit; the
//   stage data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_to_rgb_fixed_point #(
    parameter int unsigned FRAC_BITS = 12
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [hsl_pkg::HUE_W-1:0]    i_hue,
    input  wire logic [hsl_pkg::LUM_W-1:0]    i_lightness,
    input  wire logic [hsl_pkg::SAT_W-1:0]    i_saturation,
    input  wire logic [hsl_pkg::SCALE_W-1:0]  i_scale,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [hsl_pkg::CHAN_W-1:0]        o_red,
    output logic [hsl_pkg::CHAN_W-1:0]        o_green,
    output logic [hsl_pkg::CHAN_W-1:0]        o_blue
);

    logic                         en;

    hsl_pkg::t_ctrl               front_ctrl;
    logic [hsl_pkg::LUM_W-1:0]    front_lum;
    logic [hsl_pkg::SAT_W-1:0]    front_sat;
    logic [hsl_pkg::SCALE_W-1:0]  front_scale;
    logic [hsl_pkg::LUM_W-1:0]    front_p;
    logic [FRAC_BITS:0]           front_w;

    hsl_pkg::t_ctrl               level_ctrl;
    logic [hsl_pkg::LEV_W-1:0]    level_top;
    logic [hsl_pkg::LEV_W-1:0]    level_lo;
    logic [hsl_pkg::LEV_W-1:0]    level_diff;
    logic [FRAC_BITS:0]           level_w;

    // pipe advances unless a finished beat is held by the receiver
    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    hsl_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_valid),
        .i_hue        (i_hue),
        .i_lightness  (i_lightness),
        .i_saturation (i_saturation),
        .i_scale      (i_scale),
        .o_ctrl       (front_ctrl),
        .o_lum        (front_lum),
        .o_sat        (front_sat),
        .o_scale      (front_scale),
        .o_p          (front_p),
        .o_w          (front_w)
    );

    hsl_level #(
        .FRAC_BITS (FRAC_BITS)
    ) u_level (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctrl  (front_ctrl),
        .i_lum   (front_lum),
        .i_sat   (front_sat),
        .i_scale (front_scale),
        .i_p     (front_p),
        .i_w     (front_w),
        .o_ctrl  (level_ctrl),
        .o_top   (level_top),
        .o_lo    (level_lo),
        .o_diff  (level_diff),
        .o_w     (level_w)
    );

    hsl_ramp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ramp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctrl  (level_ctrl),
        .i_top   (level_top),
        .i_lo    (level_lo),
        .i_diff  (level_diff),
        .i_w     (level_w),
        .o_valid (o_valid),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

endmodule

`default_nettype wire

>>> design/hsl_front.sv
// ----------------------------------------------------------------------------
// hsl_front
// input clamp, sector decode and lightness-saturation product (stages 1-2)
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_front #(
    parameter int unsigned FRAC_BITS = 12
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic [hsl_pkg::HUE_W-1:0]    i_hue,
    input  wire logic [hsl_pkg::LUM_W-1:0]    i_lightness,
    input  wire logic [hsl_pkg::SAT_W-1:0]    i_saturation,
    input  wire logic [hsl_pkg::SCALE_W-1:0]  i_scale,
    output hsl_pkg::t_ctrl                    o_ctrl,
    output logic [hsl_pkg::LUM_W-1:0]         o_lum,
    output logic [hsl_pkg::SAT_W-1:0]         o_sat,
    output logic [hsl_pkg::SCALE_W-1:0]       o_scale,
    output logic [hsl_pkg::LUM_W-1:0]         o_p,
    output logic [FRAC_BITS:0]                o_w
);

    localparam int unsigned ONE   = 1 << FRAC_BITS;
    localparam int unsigned HALF  = ONE >> 1;
    localparam int unsigned W1    = FRAC_BITS + 1;
    localparam int unsigned SUM_W = ((hsl_pkg::HUE_W > W1) ? hsl_pkg::HUE_W : W1) + 1;
    localparam int unsigned SEC_W = SUM_W - FRAC_BITS;
    localparam int unsigned MW    = SEC_W + 3;
    localparam int unsigned PW    = hsl_pkg::LUM_W + W1;

    // restoring reduction of the sector count modulo six
    function automatic logic [2:0] mod6(input logic [SEC_W-1:0] s);
        logic [MW-1:0] v;
        v = MW'(s);
        for (int j = SEC_W - 1; j >= 0; j--) begin
            if (v >= (MW'(6) << j)) begin
                v = v - (MW'(6) << j);
            end
        end
        return v[2:0];
    endfunction

    logic [SUM_W-1:0]           n_sum;
    logic [2:0]                 n_m;
    logic [hsl_pkg::LUM_W-1:0]  n_lum;
    logic [hsl_pkg::SAT_W-1:0]  n_sat;

    logic                         r1_valid;
    logic [2:0]                   r1_m;
    logic [FRAC_BITS-1:0]         r1_frac;
    logic [hsl_pkg::LUM_W-1:0]    r1_lum;
    logic [hsl_pkg::SAT_W-1:0]    r1_sat;
    logic [hsl_pkg::SCALE_W-1:0]  r1_scale;

    logic [W1-1:0]              n_oms;
    logic [PW-1:0]              n_prod;
    logic [W1-1:0]              n_w;
    hsl_pkg::t_ctrl             n_ctrl;

    hsl_pkg::t_ctrl               r2_ctrl;
    logic [hsl_pkg::LUM_W-1:0]    r2_lum;
    logic [hsl_pkg::SAT_W-1:0]    r2_sat;
    logic [hsl_pkg::SCALE_W-1:0]  r2_scale;
    logic [hsl_pkg::LUM_W-1:0]    r2_p;
    logic [W1-1:0]                r2_w;

    // stage 1: offset hue by one sector, split sector and fraction, clamp
    always_comb begin
        n_sum = SUM_W'(i_hue) + SUM_W'(ONE);
        n_m   = mod6(n_sum[SUM_W-1:FRAC_BITS]);
        n_lum = (32'(i_lightness) > ONE) ? hsl_pkg::LUM_W'(ONE) : i_lightness;
        n_sat = (32'(i_saturation) > ONE) ? hsl_pkg::SAT_W'(ONE) : i_saturation;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_m     <= n_m;
            r1_frac  <= n_sum[FRAC_BITS-1:0];
            r1_lum   <= n_lum;
            r1_sat   <= n_sat;
            r1_scale <= i_scale;
        end
    end

    // stage 2: lum * (one - sat), ramp weight and channel roles
    always_comb begin
        n_oms           = W1'(ONE - 32'(r1_sat));
        n_prod          = PW'(r1_lum) * PW'(n_oms);
        n_w             = r1_m[0] ? W1'(r1_frac) : W1'(ONE - 32'(r1_frac));
        n_ctrl.valid    = r1_valid;
        n_ctrl.route    = hsl_pkg::route_of(r1_m);
        n_ctrl.low_half = (32'(r1_lum) <= HALF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctrl <= '0;
        end else if (i_en) begin
            r2_ctrl <= n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_lum   <= r1_lum;
            r2_sat   <= r1_sat;
            r2_scale <= r1_scale;
            r2_p     <= n_prod[FRAC_BITS +: hsl_pkg::LUM_W];
            r2_w     <= n_w;
        end
    end

    assign o_ctrl  = r2_ctrl;
    assign o_lum   = r2_lum;
    assign o_sat   = r2_sat;
    assign o_scale = r2_scale;
    assign o_p     = r2_p;
    assign o_w     = r2_w;

endmodule

`default_nettype wire

>>> design/hsl_level.sv
// ----------------------------------------------------------------------------
// hsl_level
// scaled max and min channel levels and their spread (stages 3-4)
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_level #(
    parameter int unsigned FRAC_BITS = 12
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire hsl_pkg::t_ctrl               i_ctrl,
    input  wire logic [hsl_pkg::LUM_W-1:0]    i_lum,
    input  wire logic [hsl_pkg::SAT_W-1:0]    i_sat,
    input  wire logic [hsl_pkg::SCALE_W-1:0]  i_scale,
    input  wire logic [hsl_pkg::LUM_W-1:0]    i_p,
    input  wire logic [FRAC_BITS:0]           i_w,
    output hsl_pkg::t_ctrl                    o_ctrl,
    output logic [hsl_pkg::LEV_W-1:0]         o_top,
    output logic [hsl_pkg::LEV_W-1:0]         o_lo,
    output logic [hsl_pkg::LEV_W-1:0]         o_diff,
    output logic [FRAC_BITS:0]                o_w
);

    localparam int unsigned MIX_W = hsl_pkg::MIX_W;
    localparam int unsigned LEV_W = hsl_pkg::LEV_W;

    logic [MIX_W-1:0]  n_a;
    logic [LEV_W-1:0]  n_mk;
    logic [LEV_W-1:0]  n_twolk;

    hsl_pkg::t_ctrl    r3_ctrl;
    logic [LEV_W-1:0]  r3_mk;
    logic [LEV_W-1:0]  r3_twolk;
    logic [FRAC_BITS:0] r3_w;

    logic [LEV_W-1:0]  n_top;
    logic [LEV_W-1:0]  n_lo;

    hsl_pkg::t_ctrl    r4_ctrl;
    logic [LEV_W-1:0]  r4_top;
    logic [LEV_W-1:0]  r4_lo;
    logic [LEV_W-1:0]  r4_diff;
    logic [FRAC_BITS:0] r4_w;

    // stage 3: level chosen by lightness half, times scale, and 2*lum*scale
    always_comb begin
        n_a     = i_ctrl.low_half ? MIX_W'(i_p) : MIX_W'(i_p) + MIX_W'(i_sat);
        n_mk    = LEV_W'(n_a) * LEV_W'(i_scale);
        n_twolk = (LEV_W'(i_lum) * LEV_W'(i_scale)) << 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctrl <= '0;
        end else if (i_en) begin
            r3_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_mk    <= n_mk;
            r3_twolk <= n_twolk;
            r3_w     <= i_w;
        end
    end

    // stage 4: the other level is the complement against 2*lum*scale
    always_comb begin
        if (r3_ctrl.low_half) begin
            n_lo  = r3_mk;
            n_top = r3_twolk - r3_mk;
        end else begin
            n_top = r3_mk;
            n_lo  = r3_twolk - r3_mk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctrl <= '0;
        end else if (i_en) begin
            r4_ctrl <= r3_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_top  <= n_top;
            r4_lo   <= n_lo;
            r4_diff <= n_top - n_lo;
            r4_w    <= r3_w;
        end
    end

    assign o_ctrl = r4_ctrl;
    assign o_top  = r4_top;
    assign o_lo   = r4_lo;
    assign o_diff = r4_diff;
    assign o_w    = r4_w;

endmodule

`default_nettype wire

>>> design/hsl_ramp.sv
// ----------------------------------------------------------------------------
// hsl_ramp
// ramp channel interpolation, rounding and channel routing (stages 5-6)
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_ramp #(
    parameter int unsigned FRAC_BITS = 12
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire hsl_pkg::t_ctrl              i_ctrl,
    input  wire logic [hsl_pkg::LEV_W-1:0]   i_top,
    input  wire logic [hsl_pkg::LEV_W-1:0]   i_lo,
    input  wire logic [hsl_pkg::LEV_W-1:0]   i_diff,
    input  wire logic [FRAC_BITS:0]          i_w,
    output logic                             o_valid,
    output logic [hsl_pkg::CHAN_W-1:0]       o_red,
    output logic [hsl_pkg::CHAN_W-1:0]       o_green,
    output logic [hsl_pkg::CHAN_W-1:0]       o_blue
);

    localparam int unsigned ONE    = 1 << FRAC_BITS;
    localparam int unsigned HALF   = ONE >> 1;
    localparam int unsigned LEV_W  = hsl_pkg::LEV_W;
    localparam int unsigned CHAN_W = hsl_pkg::CHAN_W;
    localparam int unsigned RW     = LEV_W + 1;
    localparam int unsigned RPW    = LEV_W + FRAC_BITS + 1;

    // add one half, drop the fraction, clip at full scale
    function automatic logic [CHAN_W-1:0] round_sat(input logic [RW-1:0] v);
        logic [RW:0] s;
        logic [RW:0] q;
        s = {1'b0, v} + (RW + 1)'(HALF);
        q = s >> FRAC_BITS;
        return (q > (RW + 1)'(hsl_pkg::CHAN_MAX)) ? CHAN_W'(hsl_pkg::CHAN_MAX)
                                                  : q[CHAN_W-1:0];
    endfunction

    logic [RPW-1:0]     n_prod;
    logic [RW-1:0]      n_ramp;

    hsl_pkg::t_ctrl     r5_ctrl;
    logic [LEV_W-1:0]   r5_top;
    logic [LEV_W-1:0]   r5_lo;
    logic [RW-1:0]      r5_ramp;

    logic [CHAN_W-1:0]  n_top_c;
    logic [CHAN_W-1:0]  n_lo_c;
    logic [CHAN_W-1:0]  n_ramp_c;
    logic [CHAN_W-1:0]  n_red;
    logic [CHAN_W-1:0]  n_green;
    logic [CHAN_W-1:0]  n_blue;

    logic               r6_valid;
    logic [CHAN_W-1:0]  r6_red;
    logic [CHAN_W-1:0]  r6_green;
    logic [CHAN_W-1:0]  r6_blue;

    // stage 5: min plus spread times weight
    always_comb begin
        n_prod = RPW'(i_diff) * RPW'(i_w);
        n_ramp = RW'(n_prod >> FRAC_BITS) + RW'(i_lo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_ctrl <= '0;
        end else if (i_en) begin
            r5_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_top  <= i_top;
            r5_lo   <= i_lo;
            r5_ramp <= n_ramp;
        end
    end

    // stage 6: round each level and steer it to its channel
    always_comb begin
        n_top_c  = round_sat(RW'(r5_top));
        n_lo_c   = round_sat(RW'(r5_lo));
        n_ramp_c = round_sat(r5_ramp);

        n_red   = (r5_ctrl.route.top == hsl_pkg::CH_RED)   ? n_top_c :
                  (r5_ctrl.route.lo  == hsl_pkg::CH_RED)   ? n_lo_c  : n_ramp_c;
        n_green = (r5_ctrl.route.top == hsl_pkg::CH_GREEN) ? n_top_c :
                  (r5_ctrl.route.lo  == hsl_pkg::CH_GREEN) ? n_lo_c  : n_ramp_c;
        n_blue  = (r5_ctrl.route.top == hsl_pkg::CH_BLUE)  ? n_top_c :
                  (r5_ctrl.route.lo  == hsl_pkg::CH_BLUE)  ? n_lo_c  : n_ramp_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r6_valid <= r5_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_red   <= n_red;
            r6_green <= n_green;
            r6_blue  <= n_blue;
        end
    end

    assign o_valid = r6_valid;
    assign o_red   = r6_red;
    assign o_green = r6_green;
    assign o_blue  = r6_blue;

endmodule

`default_nettype wire

>>> design/hsl_checker.sv
// ----------------------------------------------------------------------------
// hsl_checker
// port-level checks on the converter handshakes and pipeline timing
// ----------------------------------------------------------------------------
`default_nettype none

`include "hsl_to_rgb_fixed_point_assert.svh"

module hsl_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_valid,
    input wire logic                        o_stall,
    input wire logic                        o_valid,
    input wire logic                        i_stall,
    input wire logic [hsl_pkg::CHAN_W-1:0]  o_red,
    input wire logic [hsl_pkg::CHAN_W-1:0]  o_green,
    input wire logic [hsl_pkg::CHAN_W-1:0]  o_blue
);

    // a held result beat keeps its payload
    `HSL_ASSERT_NXT(a_hold, o_valid && i_stall, o_valid && $stable({o_red, o_green, o_blue}))

    // input is only pushed back while a result beat is held
    `HSL_ASSERT_IMP(a_stall_cause, o_stall, o_valid && i_stall)

    // an accepted beat shows up when the receiver does not stall while it travels down the pipe
    `HSL_ASSERT_NXT(a_latency, (i_valid && !o_stall) ##1 (!i_stall) [*5], o_valid)

    // reset empties the pipe
    `HSL_ASSERT_RST(a_reset, !i_rst_n, !o_valid)

endmodule

bind hsl_to_rgb_fixed_point hsl_checker u_hsl_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_red   (o_red),
    .o_green (o_green),
    .o_blue  (o_blue)
);

`default_nettype wire

>>> bench/tb_hsl_to_rgb_fixed_point.sv
// ----------------------------------------------------------------------------
// tb_hsl_to_rgb_fixed_point
// self-checking bench for the hsl to rgb converter: directed table of primary
// and secondary colours, clamping, hue wrap and the lightness midpoint, then a
// long random run with bursty input and a receiver that stalls in phases;
// every result is checked in arrival order against the table or a fixed-point predictor
// ----------------------------------------------------------------------------
module tb_hsl_to_rgb_fixed_point;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAC         = 12;
    localparam logic [63:0] UNIT         = 64'd1 << FRAC;
    localparam logic [63:0] HALF_UNIT    = UNIT >> 1;
    localparam int          RESET_CYCLES = 9;
    localparam int          N_RANDOM     = 1130;
    localparam int          MID_PAUSE_AT = 600;
    localparam int          LONG_HOLD    = 80;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          N_DIR        = 24;

    typedef struct packed {
        logic [hsl_pkg::CHAN_W-1:0] red;
        logic [hsl_pkg::CHAN_W-1:0] green;
        logic [hsl_pkg::CHAN_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [hsl_pkg::HUE_W-1:0]   hue;
        logic [hsl_pkg::LUM_W-1:0]   lum;
        logic [hsl_pkg::SAT_W-1:0]   sat;
        logic [hsl_pkg::SCALE_W-1:0] scale;
        logic                        known;
        t_rgb                        rgb;
    } t_stim;

    // directed beats: hue, lightness, saturation, scale, known, expected rgb
    localparam t_stim DIR_ROWS [N_DIR] = '{
        '{0,     0,    0,    0,   1, '{0,   0,   0}},    // all zero
        '{0,     2048, 4096, 255, 1, '{255, 0,   0}},    // red
        '{4096,  2048, 4096, 255, 1, '{255, 255, 0}},    // yellow
        '{8192,  2048, 4096, 255, 1, '{0,   255, 0}},    // green
        '{12288, 2048, 4096, 255, 1, '{0,   255, 255}},  // cyan
        '{16384, 2048, 4096, 255, 1, '{0,   0,   255}},  // blue
        '{20480, 2048, 4096, 255, 1, '{255, 0,   255}},  // magenta
        '{24576, 2048, 4096, 255, 1, '{255, 0,   0}},    // hue wraps to red
        '{32767, 2048, 4096, 255, 0, '{0,   0,   0}},    // top of hue field
        '{1000,  1000, 3000, 200, 0, '{0,   0,   0}},
        '{0,     4096, 4096, 255, 1, '{255, 255, 255}},  // white
        '{0,     8191, 0,    255, 1, '{255, 255, 255}},  // lightness clamped
        '{5000,  2048, 0,    255, 1, '{128, 128, 128}},  // mid gray
        '{5000,  1500, 8191, 255, 0, '{0,   0,   0}},    // saturation clamped
        '{7000,  8191, 8191, 0,   1, '{0,   0,   0}},    // zero scale
        '{3000,  2048, 2000, 255, 0, '{0,   0,   0}},    // lightness at half
        '{3000,  2049, 2000, 255, 0, '{0,   0,   0}},    // just above half
        '{4095,  3000, 4096, 255, 0, '{0,   0,   0}},    // sector edge
        '{24575, 1000, 4096, 255, 0, '{0,   0,   0}},    // last nominal hue
        '{12287, 4096, 0,    1,   1, '{1,   1,   1}},    // unit scale
        '{17000, 100,  4000, 128, 0, '{0,   0,   0}},
        '{32767, 8191, 8191, 255, 1, '{255, 255, 255}},  // every field at max
        '{0,     0,    4096, 255, 1, '{0,   0,   0}},    // black
        '{21000, 6000, 3000, 77,  0, '{0,   0,   0}}
    };

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_valid      = 1'b0;
    logic                          o_stall;
    logic [hsl_pkg::HUE_W-1:0]     i_hue        = '0;
    logic [hsl_pkg::LUM_W-1:0]     i_lightness  = '0;
    logic [hsl_pkg::SAT_W-1:0]     i_saturation = '0;
    logic [hsl_pkg::SCALE_W-1:0]   i_scale      = '0;
    logic                          o_valid;
    logic                          i_stall      = 1'b0;
    logic [hsl_pkg::CHAN_W-1:0]    o_red;
    logic [hsl_pkg::CHAN_W-1:0]    o_green;
    logic [hsl_pkg::CHAN_W-1:0]    o_blue;

    // typed expectation travelling with the beat being offered
    logic                 beat_known   = 1'b0;
    t_rgb                 beat_rgb     = '0;

    t_rgb                 pending_rgb [$];
    int                   beats_sent     = 0;
    int                   rgb_checked    = 0;
    int                   errors         = 0;
    int                   input_held     = 0;
    int                   cycle_count    = 0;
    int                   burst_left     = 0;

    hsl_to_rgb_fixed_point #(
        .FRAC_BITS (FRAC)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_hue        (i_hue),
        .i_lightness  (i_lightness),
        .i_saturation (i_saturation),
        .i_scale      (i_scale),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    always #5 i_clk = ~i_clk;

    // round half up, then saturate to the channel range
    function automatic logic [hsl_pkg::CHAN_W-1:0] chan_round(input logic [63:0] v);
        logic [63:0] r;
        r = (v + HALF_UNIT) >> FRAC;
        return (r > hsl_pkg::CHAN_MAX) ? hsl_pkg::CHAN_W'(hsl_pkg::CHAN_MAX)
                                       : r[hsl_pkg::CHAN_W-1:0];
    endfunction

    // fixed-point hsl to rgb conversion of one beat
    function automatic t_rgb hsl_convert(input logic [hsl_pkg::HUE_W-1:0] hue,
                                         input logic [hsl_pkg::LUM_W-1:0] lum_raw,
                                         input logic [hsl_pkg::SAT_W-1:0] sat_raw,
                                         input logic [hsl_pkg::SCALE_W-1:0] scale);
        logic [63:0]    lum;
        logic [63:0]    sat;
        logic [63:0]    k;
        logic [63:0]    pos;
        logic [63:0]    x;
        logic [63:0]    w;
        logic [63:0]    lev [3];
        int unsigned    m;
        int unsigned    sect;
        hsl_pkg::t_chan top;
        hsl_pkg::t_chan lo;
        hsl_pkg::t_chan ramp;
        t_rgb           res;
        lum = (lum_raw > UNIT) ? UNIT : 64'(lum_raw);
        sat = (sat_raw > UNIT) ? UNIT : 64'(sat_raw);
        k   = 64'(scale);

        // sector picks the max, min and ramp channels
        pos  = (64'(hue) + UNIT) % (6 * UNIT);
        m    = int'(pos >> FRAC);
        sect = m >> 1;
        top  = hsl_pkg::t_chan'(sect);
        if ((m & 1) != 0) begin
            ramp = hsl_pkg::t_chan'((sect + 1) % 3);
            lo   = hsl_pkg::t_chan'((sect + 2) % 3);
        end else begin
            lo   = hsl_pkg::t_chan'((sect + 1) % 3);
            ramp = hsl_pkg::t_chan'((sect + 2) % 3);
        end

        // min and max levels, low half includes exactly one half
        if (lum <= HALF_UNIT) begin
            lev[lo]  = ((lum * (UNIT - sat)) >> FRAC) * k;
            lev[top] = 2 * lum * k - lev[lo];
        end else begin
            lev[top] = (((lum * (UNIT - sat)) >> FRAC) + sat) * k;
            lev[lo]  = 2 * lum * k - lev[top];
        end

        // ramp channel slides between min and max
        x = pos - 64'(sect) * 2 * UNIT;
        w = (x >= UNIT) ? x - UNIT : UNIT - x;
        lev[ramp] = (((lev[top] - lev[lo]) * w) >> FRAC) + lev[lo];

        res.red   = chan_round(lev[hsl_pkg::CH_RED]);
        res.green = chan_round(lev[hsl_pkg::CH_GREEN]);
        res.blue  = chan_round(lev[hsl_pkg::CH_BLUE]);
        return res;
    endfunction

    // offer one beat, with a random gap at the start of each burst
    task automatic send_beat(input t_stim s);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 1);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid      <= 1'b1;
        i_hue        <= s.hue;
        i_lightness  <= s.lum;
        i_saturation <= s.sat;
        i_scale      <= s.scale;
        beat_known   <= s.known;
        beat_rgb     <= s.rgb;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        beats_sent++;
    endtask

    // drop valid and hold until every outstanding result is back
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (rgb_checked != beats_sent);
    endtask

    // random fill of one field, mostly in the 0..4096 fixed-point range, sometimes up to 8191
    function automatic logic [hsl_pkg::LUM_W-1:0] pick_unit();
        case ($urandom_range(9))
            0:       return hsl_pkg::LUM_W'($urandom_range(8191));
            1:       return hsl_pkg::LUM_W'(2047 + $urandom_range(2));
            2:       return $urandom_range(1) ? hsl_pkg::LUM_W'(UNIT) : '0;
            default: return hsl_pkg::LUM_W'($urandom_range(4096));
        endcase
    endfunction

    // stimulus side
    initial begin : in_side
        t_stim s;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int n = 0; n < N_DIR; n++) begin
            send_beat(DIR_ROWS[n]);
        end
        drain_results();

        // random beats
        for (int n = 0; n < N_RANDOM; n++) begin
            case ($urandom_range(7))
                0:       s.hue = hsl_pkg::HUE_W'($urandom_range(32767));
                1:       s.hue = hsl_pkg::HUE_W'(4096 * $urandom_range(6, 1) - 1
                                                 + $urandom_range(2));
                default: s.hue = hsl_pkg::HUE_W'($urandom_range(24575));
            endcase
            s.lum = pick_unit();
            s.sat = pick_unit();
            case ($urandom_range(7))
                0:       s.scale = '0;
                1:       s.scale = '1;
                default: s.scale = hsl_pkg::SCALE_W'($urandom_range(255));
            endcase
            s.known = 1'b0;
            s.rgb   = '0;
            send_beat(s);
            if (n == MID_PAUSE_AT) begin
                drain_results();
            end
        end

        // wind down
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_rgb.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $realtime, pending_rgb.size());
            errors++;
        end
        $display("covered %0d beats (%0d from the directed table), %0d results checked",
                 beats_sent, N_DIR, rgb_checked);
        $display("input held off on %0d cycles, %0d errors", input_held, errors);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // receiver stalls in phases, with one long hold-off
    initial begin : out_side
        int stretch;
        int pct;
        bit long_done;
        long_done = 1'b0;
        @(posedge i_clk);
        forever begin
            if (!long_done && rgb_checked >= 400) begin
                long_done = 1'b1;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            stretch = $urandom_range(200, 20);
            case ($urandom_range(3))
                0:       pct = 0;
                1:       pct = 20;
                2:       pct = 50;
                default: pct = 85;
            endcase
            repeat (stretch) begin
                i_stall <= ($urandom_range(99) < pct);
                @(posedge i_clk);
            end
        end
    end

    // record the expected result of each accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_stall) begin
            input_held++;
        end
        if (i_rst_n && i_valid && !o_stall) begin
            if (beat_known) begin
                pending_rgb.push_back(beat_rgb);
            end else begin
                pending_rgb.push_back(hsl_convert(i_hue, i_lightness, i_saturation, i_scale));
            end
        end
    end

    // compare each delivered beat with the oldest expectation
    always @(posedge i_clk) begin : check_out
        t_rgb want;
        if (i_rst_n && o_valid && !i_stall) begin
            rgb_checked++;
            if (pending_rgb.size() == 0) begin
                $display("%0t: unexpected result rgb %0d %0d %0d", $realtime,
                         o_red, o_green, o_blue);
                errors++;
            end else begin
                want = pending_rgb.pop_front();
                if (o_red !== want.red) begin
                    $display("%0t: red expected %0d actual %0d", $realtime, want.red, o_red);
                    errors++;
                end
                if (o_green !== want.green) begin
                    $display("%0t: green expected %0d actual %0d", $realtime,
                             want.green, o_green);
                    errors++;
                end
                if (o_blue !== want.blue) begin
                    $display("%0t: blue expected %0d actual %0d", $realtime, want.blue, o_blue);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d of %0d results back", $realtime,
                     cycle_count, rgb_checked, beats_sent);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
